FILE: rtl/lbc_pkg.sv
// ----------------------------------------------------------------------------
// lbc_pkg: shared types and constants of the LRU block cache
// Item payloads, the token that walks the slot cells, and per-cell write control.
// ----------------------------------------------------------------------------
package lbc_pkg;

  localparam int BLOCK_BYTES = 256;
  localparam int RESERVE     = 15;
  localparam int SLOTS       = 16;
  localparam int MAX_READ    = 256;
  localparam int BLOCK_WORDS = (BLOCK_BYTES + 7) / 8;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int OFF_W       = $clog2(BLOCK_BYTES);
  localparam int WORD_W      = OFF_W - 3;
  localparam int MEM_AW      = SLOT_W + WORD_W;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [31:0] start_pos;
    logic [4:0]  word_index;
    logic [63:0] data_in;
    logic [8:0]  length;
    logic        last_word;
    logic [31:0] now;
  } lbc_in_t;

  typedef struct packed {
    logic        hit;
    logic [8:0]  returned_length;
    logic [63:0] data_out;
    logic [3:0]  bytes_valid;
    logic        last;
  } lbc_out_t;

  typedef struct packed {
    logic              active;
    logic              is_read;
    logic [SLOT_W-1:0] idx;
    logic [31:0]       pos;
    logic [32:0]       stop;
    logic [31:0]       now;
    logic              found;
    logic [SLOT_W-1:0] hit_slot;
    logic [31:0]       hit_start;
    logic [CNT_W-1:0]  count;
    logic              vic_found;
    logic [SLOT_W-1:0] vic_slot;
    logic [31:0]       oldest;
    logic              free_found;
    logic [SLOT_W-1:0] free_slot;
  } lbc_token_t;

  typedef struct packed {
    logic        set;
    logic        clr;
    logic        touch;
    logic [31:0] start;
    logic [31:0] visit;
  } lbc_cell_wr_t;

endpackage

FILE: rtl/lbc_cell.sv
// ----------------------------------------------------------------------------
// lbc_cell: one cache slot tag cell
// Holds valid, start and visit time of a slot; folds them into the passing token.
// ----------------------------------------------------------------------------
module lbc_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  lbc_pkg::lbc_token_t  tok_in,
  output lbc_pkg::lbc_token_t  tok_out,
  input  lbc_pkg::lbc_cell_wr_t wr
);
  import lbc_pkg::*;

  logic        valid;
  logic [31:0] start;
  logic [31:0] visit;
  lbc_token_t  tok_next;
  logic        covers;

  assign covers = valid && (start <= tok_in.pos) &&
                  (tok_in.stop <= ({1'b0, start} + 33'(BLOCK_BYTES)));

  always_comb begin
    tok_next     = tok_in;
    tok_next.idx = tok_in.idx + 1'b1;
    if (tok_in.is_read) begin
      if (!tok_in.found && covers) begin
        tok_next.found     = 1'b1;
        tok_next.hit_slot  = tok_in.idx;
        tok_next.hit_start = start;
      end
    end else begin
      if (valid) begin
        tok_next.count = tok_in.count + 1'b1;
        // strict compare keeps the lowest slot on equal visit times
        if (visit < tok_in.oldest) begin
          tok_next.oldest    = visit;
          tok_next.vic_slot  = tok_in.idx;
          tok_next.vic_found = 1'b1;
        end
      end else if (!tok_in.free_found) begin
        tok_next.free_found = 1'b1;
        tok_next.free_slot  = tok_in.idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (wr.set) begin
        valid <= 1'b1;
      end else if (wr.clr) begin
        valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.set) begin
      start <= wr.start;
      visit <= wr.visit;
    end else if (wr.touch) begin
      visit <= wr.visit;
    end
  end

endmodule

FILE: rtl/lbc_chain.sv
// ----------------------------------------------------------------------------
// lbc_chain: row of slot cells
// A token enters at slot 0 and leaves after the last slot, one cell per cycle.
// ----------------------------------------------------------------------------
module lbc_chain (
  input  logic                  clk,
  input  logic                  rst,
  input  lbc_pkg::lbc_token_t   head,
  output lbc_pkg::lbc_token_t   tail,
  input  lbc_pkg::lbc_cell_wr_t wr [lbc_pkg::SLOTS]
);
  import lbc_pkg::*;

  lbc_token_t link [SLOTS+1];

  assign link[0] = head;
  assign tail    = link[SLOTS];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    lbc_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (link[i]),
      .tok_out (link[i+1]),
      .wr      (wr[i])
    );
  end

endmodule

FILE: rtl/lru_block_cache_top.sv
// A load word writes the staging buffer; a committing load scans the slot cells,
// then copies the staged block into block memory.
// A read scans the slot cells, passes S_RD0 and S_RD1 to start, then gives one
// result per cycle when not stalled (up to 32); one item is worked at a time.
// Reset clears all slot valid bits at once; stored data needs no clearing.
// ----------------------------------------------------------------------------
// lru_block_cache_top: fully associative block cache with LRU replacement
// Staging buffer, block memory, slot cell chain and read result sequencer.
// ----------------------------------------------------------------------------
module lru_block_cache_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lbc_pkg::lbc_in_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output lbc_pkg::lbc_out_t out_item
);
  import lbc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_COPY, S_RD0, S_RD1, S_RD2, S_ONE
  } state_t;

  state_t state;

  logic [63:0] stage_mem [BLOCK_WORDS];
  logic [63:0] block_mem [2**MEM_AW];
  logic [63:0] stg_rd;
  logic [63:0] blk_rd;

  lbc_token_t   head, tail;
  lbc_cell_wr_t wr [SLOTS];

  logic              accept;
  logic              launch;
  logic              is_commit;
  logic [31:0]       req_pos;
  logic [31:0]       req_now;
  logic [8:0]        req_len;
  logic [SLOT_W-1:0] slot;
  logic [WORD_W:0]   copy_ctr;
  logic [WORD_W-1:0] ptr;
  logic [2:0]        sh;
  logic [63:0]       lo;
  logic [8:0]        done;
  logic              hit_r;
  logic              out_free;
  logic              emit;

  // commit decision from the token leaving the chain
  logic              evict;
  logic              take_vic;
  logic              free_ok;
  logic [SLOT_W-1:0] new_slot;
  logic [OFF_W-1:0]  off;
  logic              read_hit;

  // result forming
  logic [8:0]   remain;
  logic [3:0]   cnt;
  logic [127:0] pair;
  logic [63:0]  shifted;
  logic [63:0]  word;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign is_commit = (in_item.mode == MODE_LOAD) && in_item.last_word &&
                     (in_item.length == 9'(BLOCK_BYTES));
  assign launch    = accept && ((in_item.mode == MODE_READ) || is_commit);
  assign out_free  = !out_valid || out_ready;
  assign emit      = out_free && (state == S_RD2 || state == S_ONE);

  always_comb begin
    head            = '0;
    head.active     = launch;
    head.is_read    = (in_item.mode == MODE_READ);
    head.pos        = in_item.start_pos;
    head.stop       = {1'b0, in_item.start_pos} + 33'(in_item.length);
    head.now        = in_item.now;
    head.oldest     = in_item.now;
  end

  lbc_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .tail (tail),
    .wr   (wr)
  );

  assign evict    = (32'(tail.count) > 32'(RESERVE)) && tail.vic_found;
  assign take_vic = evict && (!tail.free_found || (tail.vic_slot < tail.free_slot));
  assign free_ok  = tail.free_found || evict;
  assign new_slot = take_vic ? tail.vic_slot : tail.free_slot;
  assign read_hit = tail.found && (req_len <= 9'(MAX_READ));
  assign off      = OFF_W'(req_pos - tail.hit_start);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      wr[i]       = '0;
      wr[i].start = req_pos;
      wr[i].visit = req_now;
    end
    if (state == S_SCAN && tail.active) begin
      if (tail.is_read) begin
        if (read_hit) begin
          wr[tail.hit_slot].touch = 1'b1;
        end
      end else if (free_ok) begin
        if (evict) begin
          wr[tail.vic_slot].clr = 1'b1;
        end
        wr[new_slot].set = 1'b1;
      end
    end
  end

  // staging buffer and block memory
  always_ff @(posedge clk) begin
    if (accept && in_item.mode == MODE_LOAD &&
        32'(in_item.word_index) < 32'(BLOCK_WORDS)) begin
      stage_mem[WORD_W'(in_item.word_index)] <= in_item.data_in;
    end
    if (state == S_COPY) begin
      stg_rd <= stage_mem[copy_ctr[WORD_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_COPY && copy_ctr != '0) begin
      block_mem[{slot, WORD_W'(copy_ctr - 1'b1)}] <= stg_rd;
    end
    if (state == S_RD0 || state == S_RD1 || (state == S_RD2 && out_free)) begin
      blk_rd <= block_mem[{slot, ptr}];
    end
  end

  always_comb begin
    remain  = req_len - done;
    cnt     = (remain > 9'd8) ? 4'd8 : remain[3:0];
    pair    = {blk_rd, lo};
    shifted = 64'(pair >> {sh, 3'b000});
    for (int k = 0; k < 8; k++) begin
      word[k*8 +: 8] = (4'(k) < cnt) ? shifted[k*8 +: 8] : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (launch) begin
            req_pos <= in_item.start_pos;
            req_now <= in_item.now;
            req_len <= in_item.length;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (tail.active) begin
            done  <= '0;
            hit_r <= read_hit;
            if (tail.is_read) begin
              slot <= tail.hit_slot;
              sh   <= off[2:0];
              ptr  <= off[OFF_W-1:3];
              if (read_hit && req_len != '0) begin
                state <= S_RD0;
              end else begin
                state <= S_ONE;
              end
            end else if (free_ok) begin
              slot     <= new_slot;
              copy_ctr <= '0;
              state    <= S_COPY;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_COPY: begin
          copy_ctr <= copy_ctr + 1'b1;
          if (32'(copy_ctr) == BLOCK_WORDS) begin
            state <= S_IDLE;
          end
        end
        S_RD0: begin
          ptr   <= ptr + 1'b1;
          state <= S_RD1;
        end
        S_RD1: begin
          lo    <= blk_rd;
          ptr   <= ptr + 1'b1;
          state <= S_RD2;
        end
        S_RD2: begin
          if (out_free) begin
            out_item.hit             <= 1'b1;
            out_item.returned_length <= req_len;
            out_item.data_out        <= word;
            out_item.bytes_valid     <= cnt;
            out_item.last            <= (remain <= 9'd8);
            lo   <= blk_rd;
            ptr  <= ptr + 1'b1;
            done <= done + 9'(cnt);
            if (remain <= 9'd8) begin
              state <= S_IDLE;
            end
          end
        end
        S_ONE: begin
          if (out_free) begin
            out_item.hit             <= hit_r;
            out_item.returned_length <= '0;
            out_item.data_out        <= '0;
            out_item.bytes_valid     <= '0;
            out_item.last            <= 1'b1;
            state                    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    launch |-> ##(SLOTS) tail.active)
    else $error("token did not leave the cell chain on time");

  a_launch_idle: assert property (@(posedge clk) disable iff (rst)
    tail.active |-> (state == S_SCAN))
    else $error("token left the chain outside a scan");

  a_miss_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_item.hit) |-> (out_item.returned_length == '0 &&
      out_item.bytes_valid == '0 && out_item.last))
    else $error("miss item malformed");

  a_bv_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.bytes_valid <= 4'd8))
    else $error("bytes_valid above eight");

endmodule

FILE: verif/tb_lru_block_cache_top.sv
// ----------------------------------------------------------------------------
// tb_lru_block_cache_top: self-checking bench for the LRU block cache
// Loads whole blocks and reads back byte ranges under random idling on both
// sides. A behavioral cache model predicts every read result in order.
// ----------------------------------------------------------------------------
module tb_lru_block_cache_top;
  import lbc_pkg::*;

  logic     clk;
  logic     rst;
  logic     in_valid;
  logic     in_ready;
  lbc_in_t  in_item;
  logic     out_valid;
  logic     out_ready;
  lbc_out_t out_item;

  lru_block_cache_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_item(in_item), .out_valid(out_valid), .out_ready(out_ready),
    .out_item(out_item)
  );

  // cache image
  logic        slot_used [SLOTS];
  logic [31:0] slot_base [SLOTS];
  logic [31:0] slot_seen [SLOTS];
  logic [63:0] slot_words [SLOTS][BLOCK_WORDS];
  logic [63:0] stage_words [BLOCK_WORDS];
  lbc_out_t    pending_reads [$];

  int  errors;
  int  idle_cycles;
  bit  sender_idles;
  bit  receiver_idles;
  int  hold_off;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Predict the effect of one item.
  task automatic predict_item(input lbc_in_t it);
    int i, cnt, victim;
    logic [31:0] oldest, off;
    logic [63:0] word;
    int done, k, b;
    lbc_out_t r;
    if (it.mode == MODE_LOAD) begin
      if (it.word_index < BLOCK_WORDS) stage_words[it.word_index] = it.data_in;
      if (it.last_word && it.length == BLOCK_BYTES) begin
        cnt = 0;
        for (i = 0; i < SLOTS; i++) if (slot_used[i]) cnt++;
        if (cnt > RESERVE) begin
          victim = -1;
          oldest = it.now;
          for (i = 0; i < SLOTS; i++)
            if (slot_used[i] && slot_seen[i] < oldest) begin
              oldest = slot_seen[i];
              victim = i;
            end
          if (victim >= 0) slot_used[victim] = 1'b0;
        end
        for (i = 0; i < SLOTS; i++)
          if (!slot_used[i]) begin
            slot_used[i] = 1'b1;
            slot_base[i] = it.start_pos;
            slot_seen[i] = it.now;
            for (k = 0; k < BLOCK_WORDS; k++) slot_words[i][k] = stage_words[k];
            break;
          end
      end
      return;
    end
    if (it.length <= MAX_READ) begin
      for (i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && slot_base[i] <= it.start_pos &&
            ({1'b0, it.start_pos} + it.length) <= ({1'b0, slot_base[i]} + BLOCK_BYTES)) begin
          off = it.start_pos - slot_base[i];
          slot_seen[i] = it.now;
          done = 0;
          do begin
            cnt = it.length - done;
            if (cnt > 8) cnt = 8;
            word = '0;
            for (k = 0; k < cnt; k++) begin
              b = off + done + k;
              word[k*8 +: 8] = slot_words[i][b >> 3][(b & 7)*8 +: 8];
            end
            done += cnt;
            r.hit = 1'b1;
            r.returned_length = it.length;
            r.data_out = word;
            r.bytes_valid = cnt[3:0];
            r.last = (done >= it.length);
            pending_reads.push_back(r);
          end while (done < it.length);
          return;
        end
      end
    end
    r = '0;
    r.last = 1'b1;
    pending_reads.push_back(r);
  endtask

  // Offer one item, honoring the sender's idle bursts; valid stays up after
  // the accept until the next item or a drain drops it.
  task automatic send_item(input lbc_in_t it);
    int gap;
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
  endtask

  // Commit a block after writing nwords staging words; a full load writes
  // every word in order, a short one writes words at random indices.
  task automatic load_block(input logic [31:0] base, input logic [31:0] ms,
                            input bit random_data, input int nwords);
    lbc_in_t it;
    for (int w = 0; w < nwords; w++) begin
      it = '0;
      it.mode = MODE_LOAD;
      it.start_pos = base;
      it.word_index = (nwords == BLOCK_WORDS) ? w[4:0] : 5'($urandom);
      it.data_in = random_data ? {$urandom, $urandom} : {32'hA5A5_0000 | w, base};
      it.length = 9'(BLOCK_BYTES);
      it.last_word = (w == nwords - 1);
      it.now = ms;
      send_item(it);
    end
  endtask

  task automatic read_range(input logic [31:0] pos, input logic [8:0] len,
                            input logic [31:0] ms);
    lbc_in_t it;
    it = '0;
    it.mode = MODE_READ;
    it.start_pos = pos;
    it.length = len;
    it.now = ms;
    it.word_index = 5'($urandom);
    it.data_in = {$urandom, $urandom};
    it.last_word = 1'($urandom);
    send_item(it);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic test_directed();
    lbc_in_t it;
    load_block(32'h0000_1000, 32'd10, 1'b0, BLOCK_WORDS);
    load_block(32'hFFFF_FF00, 32'd11, 1'b1, 4);
    read_range(32'h0000_1000, 9'd256, 32'd12);
    read_range(32'h0000_1003, 9'd13, 32'd13);
    read_range(32'h0000_10FF, 9'd1, 32'd14);
    read_range(32'h0000_1080, 9'd0, 32'd15);
    read_range(32'h0000_1001, 9'd256, 32'd16);
    read_range(32'hFFFF_FF00, 9'd256, 32'hFFFF_FFFF);
    read_range(32'hFFFF_FFF8, 9'd8, 32'd17);
    read_range(32'h0000_1000, 9'd257, 32'd18);
    read_range(32'h0000_1000, 9'd511, 32'd18);
    read_range(32'h0000_0000, 9'd4, 32'd19);
    // wrong length: no commit, staging kept
    it = '0;
    it.mode = MODE_LOAD;
    it.start_pos = 32'h0000_2000;
    it.word_index = 5'd31;
    it.data_in = '1;
    it.length = 9'd255;
    it.last_word = 1'b1;
    send_item(it);
    read_range(32'h0000_2000, 9'd8, 32'd20);
    // commit with no new words: reuses staged data
    it.length = 9'd256;
    it.now = 32'd21;
    send_item(it);
    read_range(32'h0000_20F8, 9'd8, 32'd22);
    drain_results();
  endtask

  // Fill all slots then force evictions, including a no-victim drop.
  task automatic test_eviction();
    for (int s = 0; s < 16; s++) load_block(32'h0001_0000 + s * 512, 32'd100 + s, 1'b1, 1);
    read_range(32'h0001_0000, 9'd16, 32'd200);
    load_block(32'h0003_0000, 32'd201, 1'b1, 1);
    read_range(32'h0001_0200, 9'd8, 32'd202);
    read_range(32'h0003_0010, 9'd20, 32'd203);
    load_block(32'h0004_0000, 32'd0, 1'b1, 1);
    read_range(32'h0004_0000, 9'd8, 32'd204);
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_off = 400;
    for (int i = 0; i < 6; i++) read_range(32'h0001_0000 + i * 512, 9'd256, clock_ms + i);
    drain_results();
  endtask

  task automatic test_random(input int items);
    logic [31:0] base;
    logic [8:0]  len;
    int          slot;
    for (int n = 0; n < items; n++) begin
      clock_ms = clock_ms + $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) begin
        load_block($urandom, clock_ms, 1'b1, $urandom_range(1, 3));
      end else if ($urandom_range(0, 9) == 0) begin
        lbc_in_t it;
        it = $bits(lbc_in_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
        it.mode = MODE_LOAD;
        it.last_word = 1'($urandom_range(0, 1));
        it.length = $urandom_range(0, 1) ? 9'(BLOCK_BYTES) : 9'($urandom);
        it.now = clock_ms;
        send_item(it);
      end else begin
        slot = $urandom_range(0, SLOTS - 1);
        len = ($urandom_range(0, 4) == 0) ? 9'($urandom) : 9'($urandom_range(0, 40));
        base = slot_used[slot] ? slot_base[slot] + $urandom_range(0, 250) : $urandom;
        if ($urandom_range(0, 7) == 0) base = $urandom;
        read_range(base, len, clock_ms);
      end
    end
  endtask

  // receiver
  initial begin
    out_ready = 1'b0;
    hold_off = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off = hold_off - 1;
      end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        hold_off = $urandom_range(1, 17) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    lbc_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        $error("unexpected result %h", out_item);
        errors++;
      end else begin
        want = pending_reads.pop_front();
        if (out_item.hit !== want.hit) begin
          $error("hit: expected %h, got %h", want.hit, out_item.hit);
          errors++;
        end
        if (out_item.returned_length !== want.returned_length) begin
          $error("returned_length: expected %h, got %h",
                 want.returned_length, out_item.returned_length);
          errors++;
        end
        if (out_item.data_out !== want.data_out) begin
          $error("data_out: expected %h, got %h", want.data_out, out_item.data_out);
          errors++;
        end
        if (out_item.bytes_valid !== want.bytes_valid) begin
          $error("bytes_valid: expected %h, got %h", want.bytes_valid, out_item.bytes_valid);
          errors++;
        end
        if (out_item.last !== want.last) begin
          $error("last: expected %h, got %h", want.last, out_item.last);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    clock_ms = 32'd1000;
    in_valid = 1'b0;
    in_item = '0;
    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    for (int i = 0; i < BLOCK_WORDS; i++) stage_words[i] = '0;
    rst = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_eviction();
    clock_ms = 32'd1000;
    test_backpressure();
    test_random(22);
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    test_random(10);
    drain_results();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: filelist.f
rtl/lbc_pkg.sv
rtl/lbc_cell.sv
rtl/lbc_chain.sv
rtl/lru_block_cache_top.sv
verif/tb_lru_block_cache_top.sv
